### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file mhpq_chk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define AST_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg
// Constants, codes and interface types of the max-heap priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package mhpq_pkg;

    localparam int CAPACITY   = 64;
    localparam int MAP_DEPTH  = 256;
    localparam int VALUE_BITS = 32;

    localparam int VAL_W   = VALUE_BITS;
    localparam int SLOT_W  = $clog2(CAPACITY + 1);
    localparam int MAP_AW  = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int OP_W    = 3;
    localparam int ST_W    = 2;
    localparam int COUNT_W = 7;

    localparam int IN_BITS  = OP_W + VAL_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = ST_W + VAL_W + 1 + COUNT_W + VAL_W + 1;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic signed [VAL_W-1:0] MAP_LIM = VAL_W'(MAP_DEPTH);

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT   = 3'd0;
    localparam logic [OP_W-1:0] OP_POP      = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE   = 3'd2;
    localparam logic [OP_W-1:0] OP_CONTAINS = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;

    // status codes
    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_MISS = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL = 2'd2;

    // datapath micro-operations
    localparam int UOP_W = 5;
    localparam logic [UOP_W-1:0] UOP_NOP       = 5'd0;
    localparam logic [UOP_W-1:0] UOP_ACCEPT    = 5'd1;
    localparam logic [UOP_W-1:0] UOP_INS       = 5'd2;
    localparam logic [UOP_W-1:0] UOP_FULL      = 5'd3;
    localparam logic [UOP_W-1:0] UOP_MISS      = 5'd4;
    localparam logic [UOP_W-1:0] UOP_POP       = 5'd5;
    localparam logic [UOP_W-1:0] UOP_LOADLAST  = 5'd6;
    localparam logic [UOP_W-1:0] UOP_RD_MAP    = 5'd7;
    localparam logic [UOP_W-1:0] UOP_SCAN_INIT = 5'd8;
    localparam logic [UOP_W-1:0] UOP_RD_IDX    = 5'd9;
    localparam logic [UOP_W-1:0] UOP_IDX_INC   = 5'd10;
    localparam logic [UOP_W-1:0] UOP_FOUND     = 5'd11;
    localparam logic [UOP_W-1:0] UOP_REM       = 5'd12;
    localparam logic [UOP_W-1:0] UOP_UP_RD     = 5'd13;
    localparam logic [UOP_W-1:0] UOP_UP_MOVE   = 5'd14;
    localparam logic [UOP_W-1:0] UOP_DN_RD     = 5'd15;
    localparam logic [UOP_W-1:0] UOP_DN_MOVE   = 5'd16;
    localparam logic [UOP_W-1:0] UOP_PLACE     = 5'd17;
    localparam logic [UOP_W-1:0] UOP_CLEAR     = 5'd18;

    typedef struct packed {
        logic [UOP_W-1:0] uop;
        logic             out_ld;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            cnt_zero;
        logic            full;
        logic            map_hit;
        logic            rd_eq;
        logic            idx_eq_cnt;
        logic            idx_one;
        logic            first;
        logic            up_gt;
        logic            dn_move;
        logic            out_busy;
    } t_stat;

    function automatic logic f_mapped(input logic signed [VAL_W-1:0] v);
        return (v >= 0) && (v < MAP_LIM);
    endfunction

endpackage

`default_nettype wire

### hw/rtl/mhpq_datapath.sv
// ----------------------------------------------------------------------------
// mhpq_datapath
// Heap store, position map, counters and result register of the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_datapath (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [mhpq_pkg::IN_W-1:0]  i_in_data,
    input  wire mhpq_pkg::t_cmd             i_cmd,
    input  wire logic                       i_out_ready,
    output mhpq_pkg::t_stat                 o_stat,
    output logic                            o_out_valid,
    output logic [mhpq_pkg::OUT_W-1:0]      o_out_data
);

    localparam int VW = mhpq_pkg::VAL_W;
    localparam int SW = mhpq_pkg::SLOT_W;
    localparam int AW = mhpq_pkg::MAP_AW;

    logic signed [VW-1:0] hmem [0:mhpq_pkg::CAPACITY];
    logic [SW-1:0]        mmem [0:mhpq_pkg::MAP_DEPTH-1];
    logic [mhpq_pkg::MAP_DEPTH-1:0] r_mv;

    logic [mhpq_pkg::OP_W-1:0] r_opc;
    logic signed [VW-1:0] r_key, r_val, r_top, r_popped, r_rd_a, r_rd_b;
    logic [SW-1:0]        r_cnt, r_idx, r_map_q;
    logic                 r_first, r_found, r_mv_q, r_ovalid;
    logic [mhpq_pkg::ST_W-1:0] r_status;
    logic [mhpq_pkg::OUT_W-1:0] r_odata;

    logic [SW:0]          child_l, child_r;
    logic                 l_ok, r_ok, l_gt, pick_r, dn_move;
    logic signed [VW-1:0] dn_val;
    logic [SW-1:0]        dn_idx, a_addr, b_addr, h_waddr, m_wslot, n_cnt;
    logic signed [VW-1:0] h_wdata, m_wkey;
    logic                 h_we, m_wr, m_we, top_valid;
    logic [AW-1:0]        m_widx, key_idx;
    logic [mhpq_pkg::UOP_W-1:0] uop;

    assign uop     = i_cmd.uop;
    assign child_l = {r_idx, 1'b0};
    assign child_r = {r_idx, 1'b1};
    assign l_ok    = child_l <= {1'b0, r_cnt};
    assign r_ok    = child_r <= {1'b0, r_cnt};
    assign l_gt    = l_ok && (r_rd_a > r_val);
    assign pick_r  = l_gt ? (r_ok && (r_rd_b > r_rd_a)) : (r_ok && (r_rd_b > r_val));
    assign dn_move = l_gt || pick_r;
    assign dn_val  = pick_r ? r_rd_b : r_rd_a;
    assign dn_idx  = pick_r ? child_r[SW-1:0] : child_l[SW-1:0];
    assign key_idx = r_key[AW-1:0];
    assign b_addr  = child_r[SW-1:0];
    assign top_valid = (r_cnt != '0);

    always_comb begin
        a_addr  = r_idx;
        h_we    = 1'b0;
        h_waddr = r_idx;
        h_wdata = r_val;
        m_wr    = 1'b0;
        m_wkey  = r_val;
        m_wslot = r_idx;
        case (uop)
            mhpq_pkg::UOP_POP: begin
                a_addr  = r_cnt;
                m_wr    = 1'b1;
                m_wkey  = r_top;
                m_wslot = '0;
            end
            mhpq_pkg::UOP_REM: begin
                a_addr  = r_cnt;
                m_wr    = 1'b1;
                m_wkey  = r_key;
                m_wslot = '0;
            end
            mhpq_pkg::UOP_RD_MAP: a_addr = r_map_q;
            mhpq_pkg::UOP_UP_RD:  a_addr = r_idx >> 1;
            mhpq_pkg::UOP_DN_RD:  a_addr = child_l[SW-1:0];
            mhpq_pkg::UOP_UP_MOVE: begin
                h_we    = 1'b1;
                h_wdata = r_rd_a;
                m_wr    = 1'b1;
                m_wkey  = r_rd_a;
            end
            mhpq_pkg::UOP_DN_MOVE: begin
                h_we    = 1'b1;
                h_wdata = dn_val;
                m_wr    = 1'b1;
                m_wkey  = dn_val;
            end
            mhpq_pkg::UOP_PLACE: begin
                h_we = 1'b1;
                m_wr = 1'b1;
            end
            default: ;
        endcase
    end

    assign m_we   = m_wr && mhpq_pkg::f_mapped(m_wkey);
    assign m_widx = m_wkey[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (h_we) begin
            hmem[h_waddr] <= h_wdata;
        end
        r_rd_a <= hmem[a_addr];
        r_rd_b <= hmem[b_addr];
        if (m_we) begin
            mmem[m_widx] <= m_wslot;
        end
        r_map_q <= mmem[key_idx];
        r_mv_q  <= r_mv[key_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || uop == mhpq_pkg::UOP_CLEAR) begin
            r_mv <= '0;
        end else if (m_we) begin
            r_mv[m_widx] <= 1'b1;
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        case (uop)
            mhpq_pkg::UOP_INS:   n_cnt = r_cnt + SW'(1);
            mhpq_pkg::UOP_POP,
            mhpq_pkg::UOP_REM:   n_cnt = r_cnt - SW'(1);
            mhpq_pkg::UOP_CLEAR: n_cnt = '0;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (h_we && h_waddr == SW'(1)) begin
            r_top <= h_wdata;
        end
        case (uop)
            mhpq_pkg::UOP_ACCEPT: begin
                r_opc    <= i_in_data[mhpq_pkg::OP_W-1:0];
                r_key    <= i_in_data[mhpq_pkg::OP_W +: VW];
                r_val    <= i_in_data[mhpq_pkg::OP_W +: VW];
                r_popped <= '0;
                r_found  <= 1'b0;
                r_status <= mhpq_pkg::ST_OK;
            end
            mhpq_pkg::UOP_INS: begin
                r_idx   <= r_cnt + SW'(1);
                r_first <= 1'b0;
            end
            mhpq_pkg::UOP_FULL: r_status <= mhpq_pkg::ST_FULL;
            mhpq_pkg::UOP_MISS: r_status <= mhpq_pkg::ST_MISS;
            mhpq_pkg::UOP_POP: begin
                r_popped <= r_top;
                r_idx    <= SW'(1);
                r_first  <= 1'b0;
            end
            mhpq_pkg::UOP_LOADLAST:  r_val   <= r_rd_a;
            mhpq_pkg::UOP_RD_MAP:    r_idx   <= r_map_q;
            mhpq_pkg::UOP_SCAN_INIT: r_idx   <= SW'(1);
            mhpq_pkg::UOP_IDX_INC:   r_idx   <= r_idx + SW'(1);
            mhpq_pkg::UOP_FOUND:     r_found <= 1'b1;
            mhpq_pkg::UOP_REM:       r_first <= 1'b1;
            mhpq_pkg::UOP_UP_MOVE: begin
                r_idx   <= r_idx >> 1;
                r_first <= 1'b0;
            end
            mhpq_pkg::UOP_DN_MOVE:   r_idx   <= dn_idx;
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_odata <= mhpq_pkg::OUT_W'({top_valid, (top_valid ? r_top : VW'(0)),
                       mhpq_pkg::COUNT_W'(r_cnt), r_found, r_popped, r_status});
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

    assign o_stat.op         = r_opc;
    assign o_stat.cnt_zero   = (r_cnt == '0);
    assign o_stat.full       = (r_cnt >= SW'(mhpq_pkg::CAPACITY));
    assign o_stat.map_hit    = mhpq_pkg::f_mapped(r_key) && r_mv_q && (r_map_q != '0)
                               && (r_map_q <= r_cnt);
    assign o_stat.rd_eq      = (r_rd_a == r_key);
    assign o_stat.idx_eq_cnt = (r_idx == r_cnt);
    assign o_stat.idx_one    = (r_idx == SW'(1));
    assign o_stat.first      = r_first;
    assign o_stat.up_gt      = (r_val > r_rd_a);
    assign o_stat.dn_move    = dn_move;
    assign o_stat.out_busy   = r_ovalid && !i_out_ready;

endmodule

`default_nettype wire

### hw/rtl/mhpq_ctrl.sv
// ----------------------------------------------------------------------------
// mhpq_ctrl
// Sequencer of the queue: decodes each beat and steps the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire mhpq_pkg::t_stat i_stat,
    output logic                 o_in_ready,
    output mhpq_pkg::t_cmd       o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DEC      = 4'd1;
    localparam logic [3:0] S_LOC1     = 4'd2;
    localparam logic [3:0] S_LOC2     = 4'd3;
    localparam logic [3:0] S_SCAN_RD  = 4'd4;
    localparam logic [3:0] S_SCAN_CMP = 4'd5;
    localparam logic [3:0] S_HIT      = 4'd6;
    localparam logic [3:0] S_POPLD    = 4'd7;
    localparam logic [3:0] S_REMLD    = 4'd8;
    localparam logic [3:0] S_UP_RD    = 4'd9;
    localparam logic [3:0] S_UP_CMP   = 4'd10;
    localparam logic [3:0] S_DN_RD    = 4'd11;
    localparam logic [3:0] S_DN_CMP   = 4'd12;
    localparam logic [3:0] S_FIN      = 4'd13;

    logic [3:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        o_cmd.uop    = mhpq_pkg::UOP_NOP;
        o_cmd.out_ld = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.uop = mhpq_pkg::UOP_ACCEPT;
                    n_state   = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_FIN;
                case (i_stat.op)
                    mhpq_pkg::OP_INSERT: begin
                        if (i_stat.full) begin
                            o_cmd.uop = mhpq_pkg::UOP_FULL;
                        end else begin
                            o_cmd.uop = mhpq_pkg::UOP_INS;
                            n_state   = S_UP_RD;
                        end
                    end
                    mhpq_pkg::OP_POP: begin
                        if (i_stat.cnt_zero) begin
                            o_cmd.uop = mhpq_pkg::UOP_MISS;
                        end else begin
                            o_cmd.uop = mhpq_pkg::UOP_POP;
                            n_state   = S_POPLD;
                        end
                    end
                    mhpq_pkg::OP_REMOVE, mhpq_pkg::OP_CONTAINS: begin
                        if (i_stat.cnt_zero) begin
                            o_cmd.uop = mhpq_pkg::UOP_MISS;
                        end else begin
                            n_state = S_LOC1;
                        end
                    end
                    mhpq_pkg::OP_CLEAR: o_cmd.uop = mhpq_pkg::UOP_CLEAR;
                    default: ;
                endcase
            end
            S_LOC1: begin
                if (i_stat.map_hit) begin
                    o_cmd.uop = mhpq_pkg::UOP_RD_MAP;
                    n_state   = S_LOC2;
                end else begin
                    o_cmd.uop = mhpq_pkg::UOP_SCAN_INIT;
                    n_state   = S_SCAN_RD;
                end
            end
            S_LOC2: begin
                if (i_stat.rd_eq) begin
                    n_state = S_HIT;
                end else begin
                    o_cmd.uop = mhpq_pkg::UOP_SCAN_INIT;
                    n_state   = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                o_cmd.uop = mhpq_pkg::UOP_RD_IDX;
                n_state   = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (i_stat.rd_eq) begin
                    n_state = S_HIT;
                end else if (i_stat.idx_eq_cnt) begin
                    o_cmd.uop = mhpq_pkg::UOP_MISS;
                    n_state   = S_FIN;
                end else begin
                    o_cmd.uop = mhpq_pkg::UOP_IDX_INC;
                    n_state   = S_SCAN_RD;
                end
            end
            S_HIT: begin
                if (i_stat.op == mhpq_pkg::OP_CONTAINS) begin
                    o_cmd.uop = mhpq_pkg::UOP_FOUND;
                    n_state   = S_FIN;
                end else begin
                    o_cmd.uop = mhpq_pkg::UOP_REM;
                    n_state   = i_stat.idx_eq_cnt ? S_FIN : S_REMLD;
                end
            end
            S_POPLD: begin
                o_cmd.uop = mhpq_pkg::UOP_LOADLAST;
                n_state   = i_stat.cnt_zero ? S_FIN : S_DN_RD;
            end
            S_REMLD: begin
                o_cmd.uop = mhpq_pkg::UOP_LOADLAST;
                n_state   = S_UP_RD;
            end
            S_UP_RD: begin
                if (!i_stat.idx_one) begin
                    o_cmd.uop = mhpq_pkg::UOP_UP_RD;
                    n_state   = S_UP_CMP;
                end else if (i_stat.first) begin
                    n_state = S_DN_RD;
                end else begin
                    o_cmd.uop = mhpq_pkg::UOP_PLACE;
                    n_state   = S_FIN;
                end
            end
            S_UP_CMP: begin
                if (i_stat.up_gt) begin
                    o_cmd.uop = mhpq_pkg::UOP_UP_MOVE;
                    n_state   = S_UP_RD;
                end else if (i_stat.first) begin
                    n_state = S_DN_RD;
                end else begin
                    o_cmd.uop = mhpq_pkg::UOP_PLACE;
                    n_state   = S_FIN;
                end
            end
            S_DN_RD: begin
                o_cmd.uop = mhpq_pkg::UOP_DN_RD;
                n_state   = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (i_stat.dn_move) begin
                    o_cmd.uop = mhpq_pkg::UOP_DN_MOVE;
                    n_state   = S_DN_RD;
                end else begin
                    o_cmd.uop = mhpq_pkg::UOP_PLACE;
                    n_state   = S_FIN;
                end
            end
            S_FIN: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/max_heap_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// max_heap_priority_queue_unit
// Binary max-heap of signed values with a value-to-slot map; one result beat
// per command beat.
// ----------------------------------------------------------------------------
// One command is handled at a time. Clear and ignored codes go straight to
// the result. Insert climbs from the new last slot towards the root, one
// level per step. Pop moves the last entry to the root and sifts it down (at
// most 5 levels for 64 entries), unless it empties the heap. Remove and
// contains first try the slot map (values 0..255); on a hit the slot it
// names is read and compared before any rebalancing of a remove. A value
// outside the map, or a stale entry, falls back to a scan of the heap,
// one slot per step. Every heap step is one registered read of the heap
// memory followed by a compare and a write. The next command beat can be
// taken in the cycle after the result is loaded, even while that result
// still waits at the output register. A result waits for the output
// register to free up. Full-heap inserts return status 2.
// ----------------------------------------------------------------------------
`default_nettype none

module max_heap_priority_queue_unit (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // [2:0] operation, [34:3] value
    input  wire logic [mhpq_pkg::IN_W-1:0] i_s_axis_tdata,
    output logic                           o_m_axis_tvalid,
    input  wire logic                      i_m_axis_tready,
    // [1:0] status, [33:2] popped_value, [34] found, [41:35] count,
    // [73:42] top_value, [74] top_valid
    output logic [mhpq_pkg::OUT_W-1:0]     o_m_axis_tdata
);

    mhpq_pkg::t_cmd  cmd;
    mhpq_pkg::t_stat stat;

    mhpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_stat     (stat),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (cmd)
    );

    mhpq_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_s_axis_tdata),
        .i_cmd       (cmd),
        .i_out_ready (i_m_axis_tready),
        .o_stat      (stat),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

### hw/rtl/mhpq_chk.sv
// ----------------------------------------------------------------------------
// mhpq_chk
// Port-level checks of the queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mhpq_chk (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_s_axis_tvalid,
    input wire logic                      o_s_axis_tready,
    input wire logic [mhpq_pkg::IN_W-1:0] i_s_axis_tdata,
    input wire logic                      o_m_axis_tvalid,
    input wire logic                      i_m_axis_tready,
    input wire logic [mhpq_pkg::OUT_W-1:0] o_m_axis_tdata
);

    localparam int CNT_LO = mhpq_pkg::ST_W + mhpq_pkg::VAL_W + 1;
    localparam int TOP_LO = CNT_LO + mhpq_pkg::COUNT_W;
    localparam int TV_BIT = TOP_LO + mhpq_pkg::VAL_W;

    logic [mhpq_pkg::COUNT_W-1:0] cnt;
    logic [mhpq_pkg::VAL_W-1:0]   top;
    logic                         tv;

    assign cnt = o_m_axis_tdata[CNT_LO +: mhpq_pkg::COUNT_W];
    assign top = o_m_axis_tdata[TOP_LO +: mhpq_pkg::VAL_W];
    assign tv  = o_m_axis_tdata[TV_BIT];

    `AST_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata))
    `AST_IMPL(a_top_valid, i_clk, i_rst_n, o_m_axis_tvalid, tv == (cnt != '0))
    `AST_IMPL(a_top_zero, i_clk, i_rst_n, o_m_axis_tvalid && !tv, top == '0)
    `AST_IMPL(a_cnt_cap, i_clk, i_rst_n, o_m_axis_tvalid,
        cnt <= mhpq_pkg::COUNT_W'(mhpq_pkg::CAPACITY))

endmodule

bind max_heap_priority_queue_unit mhpq_chk u_mhpq_chk (.*);

`default_nettype wire
